>>> rtl/mbrtu_pkg.sv
// package for the modbus rtu frame receiver: phase type, status codes,
// register indexes and frame length constants
// no dependencies
`timescale 1ns / 1ps

package mbrtu_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MY_ADDRESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_TIME_US  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_TIMEOUT_MS = 2'd2;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_GOOD    = 3'd1;
  localparam logic [2:0] ST_ILLEGAL = 3'd2;
  localparam logic [2:0] ST_CRC_ERR = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  // frame lengths including address, function and crc
  localparam logic [8:0] LEN_FIXED = 9'd8;
  localparam logic [8:0] LEN_MULTI = 9'd9;
  localparam logic [8:0] LEN_RDWR  = 9'd13;

  localparam logic [3:0] OFS_MULTI = 4'd6;
  localparam logic [3:0] OFS_RDWR  = 4'd10;

  localparam logic [7:0] FC_WRITE_COILS = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS  = 8'd16;
  localparam logic [7:0] FC_RDWR_REGS   = 8'd23;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [9:0] US_PER_MS   = 10'd1000;
  localparam logic [2:0] GAP_HALVES  = 3'd7;
  localparam logic [18:0] GAP_THRESH_RST = 19'd7287;
  localparam logic [25:0] TIMEOUT_US_RST = 26'd500000;
  localparam logic [7:0]  MY_ADDR_RST    = 8'd1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_IGNORE,
    PH_FUNCTION,
    PH_LENGTH,
    PH_DATA
  } phase_e;

endpackage

>>> rtl/mbrtu_in_if.sv
// input channel of the modbus rtu frame receiver: valid/ready plus item payload
// no dependencies
`timescale 1ns / 1ps

interface mbrtu_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

>>> rtl/mbrtu_out_if.sv
// result channel of the modbus rtu frame receiver: valid/ready plus result payload
// no dependencies
`timescale 1ns / 1ps

interface mbrtu_out_if;
  logic       valid;
  logic       ready;
  logic       stored;
  logic [8:0] position;
  logic [7:0] byte_out;
  logic [7:0] function_code;
  logic [8:0] frame_length;
  logic [2:0] status;

  modport source (output valid, output stored, output position, output byte_out,
                  output function_code, output frame_length, output status,
                  input ready);
  modport sink   (input valid, input stored, input position, input byte_out,
                  input function_code, input frame_length, input status,
                  output ready);
endinterface

>>> rtl/modbus_rtu_frame_receiver_unit.sv
// top level of the modbus rtu frame receiver: frame delimiting, crc and timers
// depends on mbrtu_pkg, mbrtu_in_if, mbrtu_out_if
`timescale 1ns / 1ps

// channel   dir  payload
// in_s      in   func, rx_byte
// out_s     out  stored, position, byte_out, function_code, frame_length, status
// cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// one item per cycle while results are taken; an item waits in the input register,
// where the frame state and crc are updated, then sits in the result register
// a result is valid once its item moves from the input register into the result register
// a stalled result register holds the input register; ready drops only when both are full
// reset returns to the idle phase with register defaults (address 1, 1041 us, 500 ms)

module modbus_rtu_frame_receiver_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mbrtu_in_if.sink                        in_s,
  mbrtu_out_if.source                     out_s,
  input  logic                            cfg_we_i,
  input  logic [mbrtu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mbrtu_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import mbrtu_pkg::*;

  // configuration, kept in the form the compares need
  logic [7:0]  my_addr_q;
  logic [18:0] gap_thresh_q;
  logic [25:0] timeout_us_q;

  // input register
  logic       s1_valid_q;
  logic       s1_func_q;
  logic [7:0] s1_byte_q;

  // frame state
  phase_e      phase_q, phase_d;
  logic [8:0]  byte_cnt_q, byte_cnt_d;
  logic [8:0]  exp_len_q, exp_len_d;
  logic [3:0]  cnt_ofs_q, cnt_ofs_d;
  logic [7:0]  cur_func_q, cur_func_d;
  logic [15:0] crc_q, crc_d;
  logic [23:0] gap_us_q, gap_us_d;
  logic [25:0] frame_us_q, frame_us_d;
  logic        armed_q, armed_d;

  // result register
  logic       out_valid_q;
  logic       res_stored_d, res_stored_q;
  logic [8:0] res_pos_d, res_pos_q;
  logic [7:0] res_byte_d, res_byte_q;
  logic [2:0] res_status_d, res_status_q;
  logic [7:0] res_func_q;
  logic [8:0] res_len_q;

  logic        out_take;
  logic        s1_adv;
  logic        gap_open;
  phase_e      eff_phase;
  logic [15:0] crc_next;
  logic [8:0]  cnt_inc;
  logic [25:0] frame_us_inc;
  logic        timeout_hit;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  assign out_take   = !out_valid_q || out_s.ready;
  assign s1_adv     = s1_valid_q && out_take;
  assign in_s.ready = !s1_valid_q || out_take;

  // silent gap of 3.5 characters: 2*gap >= 7*char
  assign gap_open  = (phase_q == PH_IGNORE) && ({gap_us_q, 1'b0} >= {6'd0, gap_thresh_q});
  assign eff_phase = gap_open ? PH_IDLE : phase_q;
  assign crc_next  = crc_feed((eff_phase == PH_DATA || eff_phase == PH_LENGTH ||
                               eff_phase == PH_FUNCTION) ? crc_q : CRC_INIT, s1_byte_q);
  assign cnt_inc   = byte_cnt_q + 9'd1;
  assign frame_us_inc = (&frame_us_q) ? frame_us_q : frame_us_q + 26'd1;
  assign timeout_hit  = armed_q && (frame_us_inc >= timeout_us_q);

  // next state
  always_comb begin
    phase_d    = phase_q;
    byte_cnt_d = byte_cnt_q;
    exp_len_d  = exp_len_q;
    cnt_ofs_d  = cnt_ofs_q;
    cur_func_d = cur_func_q;
    crc_d      = crc_q;
    gap_us_d   = gap_us_q;
    frame_us_d = frame_us_q;
    armed_d    = armed_q;
    if (s1_func_q) begin
      gap_us_d = (&gap_us_q) ? gap_us_q : gap_us_q + 24'd1;
      if (armed_q) begin
        frame_us_d = frame_us_inc;
      end
      if (timeout_hit) begin
        armed_d = 1'b0;
        phase_d = PH_IDLE;
      end
    end else begin
      gap_us_d = '0;
      phase_d  = eff_phase;
      case (eff_phase)
        PH_IGNORE: begin
        end
        PH_FUNCTION: begin
          cur_func_d = s1_byte_q;
          crc_d      = crc_next;
          byte_cnt_d = 9'd2;
          if (s1_byte_q inside {[8'd1:8'd6]}) begin
            exp_len_d = LEN_FIXED;
            phase_d   = PH_DATA;
          end else if (s1_byte_q == FC_WRITE_COILS || s1_byte_q == FC_WRITE_REGS) begin
            exp_len_d = LEN_MULTI;
            cnt_ofs_d = OFS_MULTI;
            phase_d   = PH_LENGTH;
          end else if (s1_byte_q == FC_RDWR_REGS) begin
            exp_len_d = LEN_RDWR;
            cnt_ofs_d = OFS_RDWR;
            phase_d   = PH_LENGTH;
          end else begin
            armed_d = 1'b0;
            phase_d = PH_IDLE;
          end
        end
        PH_LENGTH: begin
          crc_d = crc_next;
          if (byte_cnt_q == {5'd0, cnt_ofs_q}) begin
            exp_len_d = exp_len_q + {1'b0, s1_byte_q};
            phase_d   = PH_DATA;
          end
          byte_cnt_d = cnt_inc;
        end
        PH_DATA: begin
          crc_d      = crc_next;
          byte_cnt_d = cnt_inc;
          if (cnt_inc >= exp_len_q) begin
            armed_d = 1'b0;
            phase_d = PH_IDLE;
          end
        end
        default: begin
          if (s1_byte_q == my_addr_q) begin
            crc_d      = crc_next;
            byte_cnt_d = 9'd1;
            exp_len_d  = '0;
            cur_func_d = '0;
            cnt_ofs_d  = '0;
            frame_us_d = '0;
            armed_d    = 1'b1;
            phase_d    = PH_FUNCTION;
          end else begin
            phase_d = PH_IGNORE;
          end
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    res_stored_d = 1'b0;
    res_pos_d    = '0;
    res_byte_d   = '0;
    res_status_d = ST_NONE;
    if (s1_func_q) begin
      if (timeout_hit) begin
        res_status_d = ST_TIMEOUT;
      end
    end else begin
      case (eff_phase)
        PH_IGNORE: begin
        end
        PH_FUNCTION: begin
          res_stored_d = 1'b1;
          res_pos_d    = 9'd1;
          res_byte_d   = s1_byte_q;
          if (!(s1_byte_q inside {[8'd1:8'd6], FC_WRITE_COILS, FC_WRITE_REGS,
                                  FC_RDWR_REGS})) begin
            res_status_d = ST_ILLEGAL;
          end
        end
        PH_LENGTH: begin
          res_stored_d = 1'b1;
          res_pos_d    = byte_cnt_q;
          res_byte_d   = s1_byte_q;
        end
        PH_DATA: begin
          res_stored_d = 1'b1;
          res_pos_d    = byte_cnt_q;
          res_byte_d   = s1_byte_q;
          if (cnt_inc >= exp_len_q) begin
            res_status_d = (crc_next == 16'h0000) ? ST_GOOD : ST_CRC_ERR;
          end
        end
        default: begin
          if (s1_byte_q == my_addr_q) begin
            res_stored_d = 1'b1;
            res_byte_d   = s1_byte_q;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_addr_q    <= MY_ADDR_RST;
      gap_thresh_q <= GAP_THRESH_RST;
      timeout_us_q <= TIMEOUT_US_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MY_ADDRESS:    my_addr_q    <= cfg_wdata_i[7:0];
        CFG_CHAR_TIME_US:  gap_thresh_q <= 19'(cfg_wdata_i) * 19'(GAP_HALVES);
        CFG_RX_TIMEOUT_MS: timeout_us_q <= 26'(cfg_wdata_i) * 26'(US_PER_MS);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_s.ready) begin
      s1_valid_q <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_s.ready && in_s.valid) begin
      s1_func_q <= in_s.func;
      s1_byte_q <= in_s.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      byte_cnt_q <= '0;
      exp_len_q  <= '0;
      cnt_ofs_q  <= '0;
      cur_func_q <= '0;
      crc_q      <= CRC_INIT;
      gap_us_q   <= '0;
      frame_us_q <= '0;
      armed_q    <= 1'b0;
    end else if (s1_adv) begin
      phase_q    <= phase_d;
      byte_cnt_q <= byte_cnt_d;
      exp_len_q  <= exp_len_d;
      cnt_ofs_q  <= cnt_ofs_d;
      cur_func_q <= cur_func_d;
      crc_q      <= crc_d;
      gap_us_q   <= gap_us_d;
      frame_us_q <= frame_us_d;
      armed_q    <= armed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_take) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_stored_q <= res_stored_d;
      res_pos_q    <= res_pos_d;
      res_byte_q   <= res_byte_d;
      res_status_q <= res_status_d;
      res_func_q   <= cur_func_d;
      res_len_q    <= exp_len_d;
    end
  end

  assign out_s.valid         = out_valid_q;
  assign out_s.stored        = res_stored_q;
  assign out_s.position      = res_pos_q;
  assign out_s.byte_out      = res_byte_q;
  assign out_s.function_code = res_func_q;
  assign out_s.frame_length  = res_len_q;
  assign out_s.status        = res_status_q;

`ifndef ASSERT_OFF
  // a frame only ends good or bad on a stored byte
  a_end_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_status_q == ST_GOOD || res_status_q == ST_CRC_ERR ||
                    res_status_q == ST_ILLEGAL) |-> res_stored_q)
    else $error("frame end reported on a byte that was not stored");

  // timeout comes from a tick, never with a stored byte
  a_timeout_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_status_q == ST_TIMEOUT |-> !res_stored_q)
    else $error("timeout reported together with a stored byte");

  // inside a frame the receive timer runs
  a_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FUNCTION || phase_q == PH_LENGTH || phase_q == PH_DATA) |-> armed_q)
    else $error("frame in progress with the timer disarmed");

  // a processed item always lands in the result register
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("processed item did not produce a result");
`endif

endmodule
